// ----- rtl/core/vcrri_pkg.sv -----
// Shared types and constants for the video chip register file with raster interrupt.
// No dependencies; imported by video_chip_register_raster_irq.
package vcrri_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [5:0] reg_addr;
        logic [7:0] write_data;
        logic [8:0] line_number;
        logic [5:0] cycle_number;
    } t_item;

    // register map
    localparam logic [5:0] ADDR_SPR_MSB    = 6'h10;
    localparam logic [5:0] ADDR_CTRL_Y     = 6'h11;
    localparam logic [5:0] ADDR_RASTER     = 6'h12;
    localparam logic [5:0] ADDR_RAW_13     = 6'h13;
    localparam logic [5:0] ADDR_RAW_14     = 6'h14;
    localparam logic [5:0] ADDR_SPR_EN     = 6'h15;
    localparam logic [5:0] ADDR_CTRL_X     = 6'h16;
    localparam logic [5:0] ADDR_SPR_YEXP   = 6'h17;
    localparam logic [5:0] ADDR_MEM_SEL    = 6'h18;
    localparam logic [5:0] ADDR_IRQ_LATCH  = 6'h19;
    localparam logic [5:0] ADDR_IRQ_MASK   = 6'h1A;
    localparam logic [5:0] ADDR_RAW_1B     = 6'h1B;
    localparam logic [5:0] ADDR_SPR_MC     = 6'h1C;
    localparam logic [5:0] ADDR_SPR_XEXP   = 6'h1D;
    localparam logic [5:0] ADDR_COLL_SS    = 6'h1E;
    localparam logic [5:0] ADDR_COLL_SB    = 6'h1F;
    localparam logic [5:0] ADDR_COLOR_BASE = 6'h20;
    localparam logic [5:0] ADDR_COLOR_END  = 6'h2E;

    // reset values
    localparam logic [7:0] RST_CTRL_Y    = 8'h9B;
    localparam logic [7:0] RST_CTRL_X    = 8'h08;
    localparam logic [7:0] RST_MEM_SEL   = 8'h14;
    localparam logic [3:0] RST_IRQ_LATCH = 4'hF;

    // raster timing
    localparam logic [8:0] CANVAS_TOP    = 9'd48;
    localparam logic [8:0] CANVAS_BOTTOM = 9'd248;
    localparam logic [8:0] DEN_LINE      = 9'h030;
    localparam logic [5:0] CYC_RASTER    = 6'd2;
    localparam logic [5:0] CYC_BADLINE   = 6'd17;
    localparam logic [5:0] CYC_RELEASE   = 6'd57;

endpackage

// ----- rtl/core/video_chip_register_raster_irq.sv -----
// Top level: register file of a raster video chip with raster interrupt and bad-line stall.
// Depends on vcrri_pkg.
//
// Each input word is a bus read, a bus write, a raster line start or a cycle tick (kind in
// s_axis_tuser). One result word comes out per input word, in order: the read byte (zero
// for anything but a read), an interrupt flag and the CPU ready level after the word. The
// block takes one word per clock while results are taken; an accepted word passes through
// the input register and then the output register, which frees the input side whenever the
// result is being taken or it is empty, so a stall downstream costs no throughput once it
// lifts. The raster interrupt (latch bit 0) is raised on a compare match at tick CYC_RASTER, on a
// compare write that changes the value to the current line, or on a control-Y write on a
// matching line other than 0; the compare register is 8 bits, so lines 256..511 never match.
// On canvas lines (48..247) cycle 17 decides the bad-line stall and cycle 57 releases it.
// Registers 0x1E/0x1F clear when read. Addresses without a decoded meaning read back the
// byte last written; the colour registers 0x20..0x2E share that raw storage.
module video_chip_register_raster_irq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] reg_addr, [13:6] write_data, [22:14] line_number, [28:23] cycle_number
    input  logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] irq_pulse, [9] cpu_ready
    output logic [15:0] m_axis_tdata
);
    import vcrri_pkg::*;

    // input register
    logic        r_in_valid;
    t_item       r_in;
    // output register
    logic        r_out_valid;
    logic [15:0] r_out;
    logic        advance;

    // chip state
    logic [7:0] r_spr_x [8];
    logic [7:0] r_spr_msb, n_spr_msb;
    logic [7:0] r_spr_y [8];
    logic [7:0] r_ctrl_y, n_ctrl_y;
    logic [7:0] r_ctrl_x, n_ctrl_x;
    logic [7:0] r_ctrl_x_pend, n_ctrl_x_pend;
    logic [7:0] r_mem_sel, n_mem_sel;
    logic [7:0] r_spr_en, n_spr_en;
    logic [7:0] r_spr_xexp, n_spr_xexp;
    logic [7:0] r_spr_yexp, n_spr_yexp;
    logic [7:0] r_spr_mc, n_spr_mc;
    logic [3:0] r_irq_latch, n_irq_latch;
    logic [3:0] r_irq_mask, n_irq_mask;
    logic [7:0] r_raster_cmp, n_raster_cmp;
    logic [8:0] r_raster_now, n_raster_now;
    logic [7:0] r_raw_13, r_raw_14, r_raw_1b;
    logic [7:0] r_coll [2];
    logic [7:0] r_raw_hi [32];          // addresses 0x20..0x3F
    logic       r_in_canvas, n_in_canvas;
    logic       r_den48, n_den48;
    logic       r_ready, n_ready;

    // datapath decode
    logic       do_step, do_read, do_write;
    logic [5:0] a;
    logic [7:0] v;
    logic [2:0] spr;
    logic [7:0] rd;
    logic       irq;
    logic       raise;
    logic       match;
    logic [3:0] raised_latch;
    logic       coll_clr;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign do_step       = r_in_valid && advance;
    assign do_read       = do_step && (r_in.mode == MODE_READ);
    assign do_write      = do_step && (r_in.mode == MODE_WRITE);
    assign a             = r_in.reg_addr;
    assign v             = r_in.write_data;
    assign spr           = a[3:1];
    assign match         = r_raster_now == {1'b0, r_raster_cmp};
    assign raised_latch  = r_irq_latch | 4'h1;
    assign coll_clr      = do_read && (a == ADDR_COLL_SS || a == ADDR_COLL_SB);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // read mux
    always_comb begin
        rd = 8'h00;
        if (a < 6'h10) begin
            rd = a[0] ? r_spr_y[spr] : r_spr_x[spr];
        end else if (a[5]) begin
            rd = (a <= ADDR_COLOR_END) ? {4'hF, r_raw_hi[a[4:0]][3:0]} : r_raw_hi[a[4:0]];
        end else begin
            unique case (a)
                ADDR_SPR_MSB:   rd = r_spr_msb;
                ADDR_CTRL_Y:    rd = {r_raster_now[8], r_ctrl_y[6:0]};
                ADDR_RASTER:    rd = r_raster_now[7:0];
                ADDR_RAW_13:    rd = r_raw_13;
                ADDR_RAW_14:    rd = r_raw_14;
                ADDR_SPR_EN:    rd = r_spr_en;
                ADDR_CTRL_X:    rd = r_ctrl_x | 8'hC0;
                ADDR_SPR_YEXP:  rd = r_spr_yexp;
                ADDR_MEM_SEL:   rd = r_mem_sel | 8'h01;
                ADDR_IRQ_LATCH: rd = (|(r_irq_latch & r_irq_mask)) ? {4'hF, r_irq_latch}
                                                                   : {4'h7, r_irq_latch};
                ADDR_IRQ_MASK:  rd = {4'hF, r_irq_mask};
                ADDR_RAW_1B:    rd = r_raw_1b;
                ADDR_SPR_MC:    rd = r_spr_mc;
                ADDR_SPR_XEXP:  rd = r_spr_xexp;
                ADDR_COLL_SS:   rd = r_coll[0];
                ADDR_COLL_SB:   rd = r_coll[1];
                default:        rd = 8'h00;
            endcase
        end
    end

    // next state for the scalar registers
    always_comb begin
        n_spr_msb     = r_spr_msb;
        n_ctrl_y      = r_ctrl_y;
        n_ctrl_x      = r_ctrl_x;
        n_ctrl_x_pend = r_ctrl_x_pend;
        n_mem_sel     = r_mem_sel;
        n_spr_en      = r_spr_en;
        n_spr_xexp    = r_spr_xexp;
        n_spr_yexp    = r_spr_yexp;
        n_spr_mc      = r_spr_mc;
        n_irq_latch   = r_irq_latch;
        n_irq_mask    = r_irq_mask;
        n_raster_cmp  = r_raster_cmp;
        n_raster_now  = r_raster_now;
        n_in_canvas   = r_in_canvas;
        n_den48       = r_den48;
        n_ready       = r_ready;
        raise         = 1'b0;
        unique case (r_in.mode)
            MODE_READ: begin
            end
            MODE_WRITE: begin
                unique case (a)
                    ADDR_SPR_MSB:   n_spr_msb = v;
                    ADDR_CTRL_Y: begin
                        n_ctrl_y = v;
                        raise    = match && (r_raster_now != 9'd0);
                    end
                    ADDR_RASTER: begin
                        if (v != r_raster_cmp) begin
                            n_raster_cmp = v;
                            raise        = r_raster_now == {1'b0, v};
                        end
                    end
                    ADDR_SPR_EN:    n_spr_en      = v;
                    ADDR_CTRL_X:    n_ctrl_x_pend = v;
                    ADDR_SPR_YEXP:  n_spr_yexp    = v;
                    ADDR_MEM_SEL:   n_mem_sel     = v;
                    ADDR_IRQ_LATCH: n_irq_latch   = r_irq_latch & ~v[3:0];
                    ADDR_IRQ_MASK:  n_irq_mask    = v[3:0];
                    ADDR_SPR_MC:    n_spr_mc      = v;
                    ADDR_SPR_XEXP:  n_spr_xexp    = v;
                    default: begin
                    end
                endcase
            end
            MODE_LINE: begin
                n_raster_now = r_in.line_number;
                n_ctrl_x     = r_ctrl_x_pend;
                n_in_canvas  = (r_in.line_number >= CANVAS_TOP) &&
                               (r_in.line_number < CANVAS_BOTTOM);
                if (r_in.line_number == DEN_LINE) begin
                    n_den48 = r_ctrl_y[4];
                end
            end
            MODE_TICK: begin
                priority if (r_in.cycle_number == CYC_RASTER) begin
                    raise = match;
                end else if (r_in.cycle_number == CYC_BADLINE) begin
                    if (r_in_canvas) begin
                        n_ready = ((r_raster_now[2:0] != r_ctrl_y[2:0]) && r_den48) ||
                                  !r_ctrl_y[4];
                    end
                end else if (r_in.cycle_number == CYC_RELEASE) begin
                    n_ready = 1'b1;
                end else begin
                end
            end
            default: begin
            end
        endcase
        if (raise) begin
            n_irq_latch = raised_latch;
        end
        irq = raise && (|(raised_latch & r_irq_mask));
    end

    // handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.mode         <= t_mode'(s_axis_tuser);
            r_in.reg_addr     <= s_axis_tdata[5:0];
            r_in.write_data   <= s_axis_tdata[13:6];
            r_in.line_number  <= s_axis_tdata[22:14];
            r_in.cycle_number <= s_axis_tdata[28:23];
        end
        if (do_step) begin
            r_out <= {6'd0, n_ready, irq, do_read ? rd : 8'h00};
        end
    end

    // chip state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_spr_x[i] <= 8'h00;
                r_spr_y[i] <= 8'h00;
            end
            for (int i = 0; i < 32; i++) begin
                r_raw_hi[i] <= 8'h00;
            end
            r_coll[0]     <= 8'h00;
            r_coll[1]     <= 8'h00;
            r_raw_13      <= 8'h00;
            r_raw_14      <= 8'h00;
            r_raw_1b      <= 8'h00;
            r_spr_msb     <= 8'h00;
            r_ctrl_y      <= RST_CTRL_Y;
            r_ctrl_x      <= RST_CTRL_X;
            r_ctrl_x_pend <= RST_CTRL_X;
            r_mem_sel     <= RST_MEM_SEL;
            r_spr_en      <= 8'h00;
            r_spr_xexp    <= 8'h00;
            r_spr_yexp    <= 8'h00;
            r_spr_mc      <= 8'h00;
            r_irq_latch   <= RST_IRQ_LATCH;
            r_irq_mask    <= 4'h0;
            r_raster_cmp  <= 8'h00;
            r_raster_now  <= 9'd0;
            r_in_canvas   <= 1'b0;
            r_den48       <= 1'b0;
            r_ready       <= 1'b1;
        end else begin
            if (do_step) begin
                r_spr_msb     <= n_spr_msb;
                r_ctrl_y      <= n_ctrl_y;
                r_ctrl_x      <= n_ctrl_x;
                r_ctrl_x_pend <= n_ctrl_x_pend;
                r_mem_sel     <= n_mem_sel;
                r_spr_en      <= n_spr_en;
                r_spr_xexp    <= n_spr_xexp;
                r_spr_yexp    <= n_spr_yexp;
                r_spr_mc      <= n_spr_mc;
                r_irq_latch   <= n_irq_latch;
                r_irq_mask    <= n_irq_mask;
                r_raster_cmp  <= n_raster_cmp;
                r_raster_now  <= n_raster_now;
                r_in_canvas   <= n_in_canvas;
                r_den48       <= n_den48;
                r_ready       <= n_ready;
            end
            // raw byte storage and sprite positions
            if (do_write) begin
                if (a < 6'h10) begin
                    if (a[0]) begin
                        r_spr_y[spr] <= v;
                    end else begin
                        r_spr_x[spr] <= v;
                    end
                end
                if (a[5]) begin
                    r_raw_hi[a[4:0]] <= v;
                end
                if (a == ADDR_RAW_13) r_raw_13  <= v;
                if (a == ADDR_RAW_14) r_raw_14  <= v;
                if (a == ADDR_RAW_1B) r_raw_1b  <= v;
                if (a == ADDR_COLL_SS) r_coll[0] <= v;
                if (a == ADDR_COLL_SB) r_coll[1] <= v;
            end
            // collision registers clear on read
            if (coll_clr) begin
                r_coll[a[0]] <= 8'h00;
            end
        end
    end

endmodule
